// ----- sv/prst_pkg.sv -----
// Shared widths, types, opcodes and CORDIC constants for the point transform core.
package prst_pkg;

	// Coordinate and operand widths.
	localparam int COORD_BITS    = 16;
	localparam int DIFF_BITS     = COORD_BITS + 1;
	localparam int ANG_BITS      = 16;
	localparam int FACT_BITS     = 16;

	// Fixed-point formats.
	localparam int ANG_FRAC      = 24;
	localparam int ANG_SHIFT     = ANG_FRAC - (ANG_BITS - 3);
	localparam int TRIG_FRAC     = 30;
	localparam int SCALE_FRAC    = 8;
	localparam int TRIG_BITS     = 32;
	localparam int Z_BITS        = 28;

	// CORDIC depth; the arctangent table holds 24 entries.
	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_COUNT    = 24;

	// Datapath widths after the multipliers.
	localparam int PROD_BITS     = TRIG_BITS + DIFF_BITS;
	localparam int CTR_BITS      = COORD_BITS + TRIG_FRAC;
	localparam int SUM_BITS      = ((PROD_BITS + 1 > CTR_BITS) ? PROD_BITS + 1 : CTR_BITS) + 1;

	typedef logic [1:0]                   op_t;
	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic signed [ANG_BITS-1:0]   ang_t;
	typedef logic signed [FACT_BITS-1:0]  fact_t;
	typedef logic signed [TRIG_BITS-1:0]  trig_t;
	typedef logic signed [Z_BITS-1:0]     z_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic signed [SUM_BITS-1:0]   sum_t;

	localparam op_t OP_ROTATE = 2'd0;
	localparam op_t OP_SCALE  = 2'd1;
	localparam op_t OP_MOVE   = 2'd2;
	localparam op_t OP_PASS   = 2'd3;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	// Angles carry 24 fraction bits inside the rotator.
	localparam z_t PI_FIX      = z_t'(52707179);
	localparam z_t HALF_PI_FIX = z_t'(26353589);
	// Reciprocal of the CORDIC gain in Q2.30.
	localparam trig_t INV_GAIN = trig_t'(652032874);

	// Everything that travels alongside the rotator.
	typedef struct packed {
		op_t    op;
		logic   flip;
		diff_t  dx;
		diff_t  dy;
		coord_t cx;
		coord_t cy;
		fact_t  fact;
		diff_t  lin_x;
		diff_t  lin_y;
	} sb_t;

	// Arctangent of 2^-i with 24 fraction bits, rounded.
	function automatic z_t atan_val(input int unsigned i);
		case (i)
			0:       return z_t'(13176795);
			1:       return z_t'(7778716);
			2:       return z_t'(4110060);
			3:       return z_t'(2086331);
			4:       return z_t'(1047214);
			5:       return z_t'(524117);
			6:       return z_t'(262123);
			7:       return z_t'(131069);
			8:       return z_t'(65536);
			9:       return z_t'(32768);
			10:      return z_t'(16384);
			11:      return z_t'(8192);
			12:      return z_t'(4096);
			13:      return z_t'(2048);
			14:      return z_t'(1024);
			15:      return z_t'(512);
			16:      return z_t'(256);
			17:      return z_t'(128);
			18:      return z_t'(64);
			19:      return z_t'(32);
			20:      return z_t'(16);
			21:      return z_t'(8);
			22:      return z_t'(4);
			23:      return z_t'(2);
			default: return '0;
		endcase
	endfunction

endpackage

// ----- sv/prst_cordic.sv -----
// Pipelined rotation-mode CORDIC, one micro-rotation per register stage.
module prst_cordic (
	input  logic            clk,
	input  logic            en,
	input  prst_pkg::z_t    z_in,
	output prst_pkg::trig_t cos_out,
	output prst_pkg::trig_t sin_out
);
	import prst_pkg::*;

	trig_t x_sc [CORDIC_STAGES];
	trig_t y_sc [CORDIC_STAGES];
	z_t    z_sc [CORDIC_STAGES-1];

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
		trig_t xp;
		trig_t yp;
		z_t    zp;

		if (k == 0) begin : g_first
			assign xp = INV_GAIN;
			assign yp = '0;
			assign zp = z_in;
		end else begin : g_next
			assign xp = x_sc[k-1];
			assign yp = y_sc[k-1];
			assign zp = z_sc[k-1];
		end

		// Arithmetic right shifts round toward minus infinity, as required.
		always_ff @(posedge clk) begin
			if (en) begin
				if (!zp[Z_BITS-1]) begin
					x_sc[k] <= xp - (yp >>> k);
					y_sc[k] <= yp + (xp >>> k);
				end else begin
					x_sc[k] <= xp + (yp >>> k);
					y_sc[k] <= yp - (xp >>> k);
				end
			end
		end

		// The last stage has no use for the residual angle.
		if (k < CORDIC_STAGES - 1) begin : g_z
			always_ff @(posedge clk) begin
				if (en) begin
					if (!zp[Z_BITS-1]) begin
						z_sc[k] <= zp - atan_val(k);
					end else begin
						z_sc[k] <= zp + atan_val(k);
					end
				end
			end
		end
	end

	assign cos_out = x_sc[CORDIC_STAGES-1];
	assign sin_out = y_sc[CORDIC_STAGES-1];

endmodule

// ----- sv/point_rotate_scale_translate_core.sv -----
// Point transform core top: rotate, scale or translate a point per cycle unless stalled.
//
// Usage: the input channel (in_valid/in_ready) carries one transaction per point:
// an opcode, the point, a center, an angle, a scale factor and a shift. The
// output channel (out_valid/out_ready) returns one transaction per input with
// the transformed point and a flag that is set when either coordinate saturated.
// Results are registered through stage 1, the CORDIC stages and stages 2 to
// 6 on their way from input acceptance to out_valid. Throughput is one point
// per clock while the skid register is empty; the sixteen-stage CORDIC pipeline
// and the multiplier stages each take a new item every cycle unless stalled.
// Reset (arst_n low) empties the pipeline and the output skid register at
// once; in_ready is high coming out of reset.
// When the receiver stalls, the last stage's result moves into a skid
// register and the pipeline keeps running that cycle, then holds; in_ready
// drops for as long as the skid register is occupied. No transaction is lost
// or duplicated across a stall.
module point_rotate_scale_translate_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  prst_pkg::op_t    opcode,
	input  prst_pkg::coord_t point_x,
	input  prst_pkg::coord_t point_y,
	input  prst_pkg::coord_t center_x,
	input  prst_pkg::coord_t center_y,
	input  prst_pkg::ang_t   angle,
	input  prst_pkg::fact_t  scale_factor,
	input  prst_pkg::coord_t shift_x,
	input  prst_pkg::coord_t shift_y,
	output logic             out_valid,
	input  logic             out_ready,
	output prst_pkg::coord_t new_x,
	output prst_pkg::coord_t new_y,
	output logic             clipped
);
	import prst_pkg::*;

	// Rounding constants for truncation toward zero.
	localparam sum_t TRIG_MASK  = sum_t'((64'd1 << TRIG_FRAC) - 64'd1);
	localparam sum_t SCALE_MASK = sum_t'((64'd1 << SCALE_FRAC) - 64'd1);
	localparam sum_t SAT_HI     = sum_t'(COORD_MAX);
	localparam sum_t SAT_LO     = sum_t'(COORD_MIN);

	// Truncating division by 2^30 (rotate) or 2^8 (scale): bias negatives
	// up by the divisor minus one, then shift arithmetically.
	function automatic sum_t trunc_div(input sum_t v, input logic rot);
		sum_t b;
		sum_t w;
		b = rot ? TRIG_MASK : SCALE_MASK;
		if (!v[SUM_BITS-1]) begin
			b = '0;
		end
		w = v + b;
		return rot ? (w >>> TRIG_FRAC) : (w >>> SCALE_FRAC);
	endfunction

	// The whole pipeline advances whenever the skid register is empty.
	logic en;
	logic skid_full_q;

	assign en       = !skid_full_q;
	assign in_ready = en;

	// Stage 1: offsets from the center, angle range reduction, translation.
	z_t    z_wide;
	z_t    z_red;
	logic  flip_c;
	sb_t   sb_c;

	always_comb begin
		z_wide = z_t'(angle) <<< ANG_SHIFT;
		z_red  = z_wide;
		flip_c = 1'b0;
		// Fold the angle into [-pi/2, pi/2]; the rotation result is negated later.
		if (z_wide > HALF_PI_FIX) begin
			z_red  = z_wide - PI_FIX;
			flip_c = 1'b1;
		end else if (z_wide < -HALF_PI_FIX) begin
			z_red  = z_wide + PI_FIX;
			flip_c = 1'b1;
		end
		sb_c.op    = opcode;
		sb_c.flip  = flip_c;
		sb_c.dx    = diff_t'(point_x) - diff_t'(center_x);
		sb_c.dy    = diff_t'(point_y) - diff_t'(center_y);
		sb_c.cx    = center_x;
		sb_c.cy    = center_y;
		sb_c.fact  = scale_factor;
		sb_c.lin_x = diff_t'(point_x);
		sb_c.lin_y = diff_t'(point_y);
		if (opcode == OP_MOVE) begin
			sb_c.lin_x = diff_t'(point_x) + diff_t'(shift_x);
			sb_c.lin_y = diff_t'(point_y) + diff_t'(shift_y);
		end
	end

	logic v_s1;
	sb_t  sb_s1;
	z_t   z_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s1 <= sb_c;
			z_s1  <= z_red;
		end
	end

	// CORDIC stages, with the side information delayed to match.
	trig_t cos_sc;
	trig_t sin_sc;

	prst_cordic u_cordic (
		.clk     (clk),
		.en      (en),
		.z_in    (z_s1),
		.cos_out (cos_sc),
		.sin_out (sin_sc)
	);

	logic v_sc  [CORDIC_STAGES];
	sb_t  sb_sc [CORDIC_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CORDIC_STAGES; k++) begin
				v_sc[k] <= 1'b0;
			end
		end else if (en) begin
			v_sc[0] <= v_s1;
			for (int k = 1; k < CORDIC_STAGES; k++) begin
				v_sc[k] <= v_sc[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_sc[0] <= sb_s1;
			for (int k = 1; k < CORDIC_STAGES; k++) begin
				sb_sc[k] <= sb_sc[k-1];
			end
		end
	end

	// Stage 2: multiplier operands. Rotation uses cos and sin (negated when
	// the angle was folded); scaling feeds the factor as "cos" and zero as "sin",
	// which leaves f*dx and f*dy after the cross terms.
	logic  v_s2;
	sb_t   sb_s2;
	trig_t c_s2;
	trig_t s_s2;

	// Stage 3: the four products.
	logic  v_s3;
	sb_t   sb_s3;
	prod_t pcx_s3;
	prod_t psy_s3;
	prod_t psx_s3;
	prod_t pcy_s3;

	// Stage 4: sums with the center added back at the right scale.
	logic  v_s4;
	sb_t   sb_s4;
	sum_t  sumx_s4;
	sum_t  sumy_s4;

	// Stage 5: truncation toward zero, or the linear result.
	logic  v_s5;
	sum_t  resx_s5;
	sum_t  resy_s5;

	// Stage 6: saturated result.
	logic   v_s6;
	coord_t x_s6;
	coord_t y_s6;
	logic   clip_s6;

	logic   rot_s3;
	sum_t   ctrx_s3;
	sum_t   ctry_s3;
	logic   clipx_c;
	logic   clipy_c;
	coord_t satx_c;
	coord_t saty_c;

	assign rot_s3  = (sb_s3.op == OP_ROTATE);
	assign ctrx_s3 = rot_s3 ? (sum_t'(sb_s3.cx) <<< TRIG_FRAC) : (sum_t'(sb_s3.cx) <<< SCALE_FRAC);
	assign ctry_s3 = rot_s3 ? (sum_t'(sb_s3.cy) <<< TRIG_FRAC) : (sum_t'(sb_s3.cy) <<< SCALE_FRAC);

	always_comb begin
		clipx_c = 1'b0;
		clipy_c = 1'b0;
		satx_c  = coord_t'(resx_s5);
		saty_c  = coord_t'(resy_s5);
		if (resx_s5 > SAT_HI) begin
			satx_c  = COORD_MAX;
			clipx_c = 1'b1;
		end else if (resx_s5 < SAT_LO) begin
			satx_c  = COORD_MIN;
			clipx_c = 1'b1;
		end
		if (resy_s5 > SAT_HI) begin
			saty_c  = COORD_MAX;
			clipy_c = 1'b1;
		end else if (resy_s5 < SAT_LO) begin
			saty_c  = COORD_MIN;
			clipy_c = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_sc[CORDIC_STAGES-1];
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s2 <= sb_sc[CORDIC_STAGES-1];
			case (sb_sc[CORDIC_STAGES-1].op)
				OP_ROTATE: begin
					c_s2 <= sb_sc[CORDIC_STAGES-1].flip ? -cos_sc : cos_sc;
					s_s2 <= sb_sc[CORDIC_STAGES-1].flip ? -sin_sc : sin_sc;
				end
				default: begin
					c_s2 <= trig_t'(sb_sc[CORDIC_STAGES-1].fact);
					s_s2 <= '0;
				end
			endcase

			sb_s3  <= sb_s2;
			pcx_s3 <= c_s2 * sb_s2.dx;
			psy_s3 <= s_s2 * sb_s2.dy;
			psx_s3 <= s_s2 * sb_s2.dx;
			pcy_s3 <= c_s2 * sb_s2.dy;

			sb_s4   <= sb_s3;
			sumx_s4 <= sum_t'(pcx_s3) - sum_t'(psy_s3) + ctrx_s3;
			sumy_s4 <= sum_t'(psx_s3) + sum_t'(pcy_s3) + ctry_s3;

			case (sb_s4.op)
				OP_ROTATE: begin
					resx_s5 <= trunc_div(sumx_s4, 1'b1);
					resy_s5 <= trunc_div(sumy_s4, 1'b1);
				end
				OP_SCALE: begin
					resx_s5 <= trunc_div(sumx_s4, 1'b0);
					resy_s5 <= trunc_div(sumy_s4, 1'b0);
				end
				default: begin
					// Translation, or the unused opcode passing the point through.
					resx_s5 <= sum_t'(sb_s4.lin_x);
					resy_s5 <= sum_t'(sb_s4.lin_y);
				end
			endcase

			x_s6    <= satx_c;
			y_s6    <= saty_c;
			clip_s6 <= clipx_c | clipy_c;
		end
	end

	// Output skid register: catches the last stage when the receiver stalls.
	coord_t skid_x_q;
	coord_t skid_y_q;
	logic   skid_clip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (!skid_full_q) begin
			skid_full_q <= v_s6 && !out_ready;
		end else if (out_ready) begin
			skid_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q) begin
			skid_x_q    <= x_s6;
			skid_y_q    <= y_s6;
			skid_clip_q <= clip_s6;
		end
	end

	assign out_valid = skid_full_q | v_s6;
	assign new_x     = skid_full_q ? skid_x_q : x_s6;
	assign new_y     = skid_full_q ? skid_y_q : y_s6;
	assign clipped   = skid_full_q ? skid_clip_q : clip_s6;

endmodule

// ----- sv/prst_checker.sv -----
// Port-level checker for the point transform core, bound to the top level.
module prst_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input prst_pkg::coord_t new_x,
	input prst_pkg::coord_t new_y,
	input logic             clipped
);
	import prst_pkg::*;

	// A stalled result transaction stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped while stalled");

	// A stalled result transaction keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(new_x) && $stable(new_y) && $stable(clipped))
		else $error("result payload changed while stalled");

	// Nothing is offered while reset is asserted.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("out_valid high during reset");

	// The input side only closes after the receiver refused a result.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(out_valid && !out_ready))
		else $error("in_ready fell without an output stall");

	// A saturated result shows a coordinate at a range limit.
	a_clip_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |->
			new_x == COORD_MAX || new_x == COORD_MIN ||
			new_y == COORD_MAX || new_y == COORD_MIN)
		else $error("clipped set with no coordinate at a limit");

endmodule

bind point_rotate_scale_translate_core prst_checker u_prst_checker (.*);

// ----- dv/point_xform_checker.sv -----
// Checker for the point transform core: predicts every transaction and compares the results.
module point_xform_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  prst_pkg::op_t    opcode,
	input  prst_pkg::coord_t point_x,
	input  prst_pkg::coord_t point_y,
	input  prst_pkg::coord_t center_x,
	input  prst_pkg::coord_t center_y,
	input  prst_pkg::ang_t   angle,
	input  prst_pkg::fact_t  scale_factor,
	input  prst_pkg::coord_t shift_x,
	input  prst_pkg::coord_t shift_y,
	input  logic             out_valid,
	input  logic             out_ready,
	input  prst_pkg::coord_t new_x,
	input  prst_pkg::coord_t new_y,
	input  logic             clipped,
	output int               mismatch_count,
	output int               points_in_flight,
	output int               results_checked,
	output int               clipped_seen
);
	import prst_pkg::*;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   clip;
	} xform_point_t;

	// Arctangent of 2^-i with 24 fraction bits.
	localparam longint ARCTAN_Q24 [24] = '{
		13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2
	};

	xform_point_t pending_points[$];

	initial begin
		mismatch_count   = 0;
		points_in_flight = 0;
		results_checked  = 0;
		clipped_seen     = 0;
	end

	function automatic longint trunc_toward_zero(input longint v, input int frac);
		if (v >= 0)
			return v >>> frac;
		return -((-v) >>> frac);
	endfunction

	function automatic longint clamp_coord(input longint v, inout logic clip);
		if (v > longint'(COORD_MAX)) begin
			clip = 1'b1;
			return longint'(COORD_MAX);
		end
		if (v < longint'(COORD_MIN)) begin
			clip = 1'b1;
			return longint'(COORD_MIN);
		end
		return v;
	endfunction

	// Rotation-mode CORDIC after folding the angle into [-pi/2, pi/2].
	function automatic void cordic_sin_cos(input ang_t ang, output longint cs, output longint sn);
		longint z;
		longint x;
		longint y;
		longint xs;
		longint ys;
		logic   flip;
		z    = longint'(ang) <<< ANG_SHIFT;
		x    = longint'(INV_GAIN);
		y    = 0;
		flip = 1'b0;
		if (z > longint'(HALF_PI_FIX)) begin
			z    = z - longint'(PI_FIX);
			flip = 1'b1;
		end else if (z < -longint'(HALF_PI_FIX)) begin
			z    = z + longint'(PI_FIX);
			flip = 1'b1;
		end
		for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - ARCTAN_Q24[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + ARCTAN_Q24[i];
			end
		end
		cs = flip ? -x : x;
		sn = flip ? -y : y;
	endfunction

	function automatic xform_point_t transform_point(input op_t op, input coord_t px,
			input coord_t py, input coord_t cx, input coord_t cy, input ang_t ang,
			input fact_t fct, input coord_t sx, input coord_t sy);
		longint       dx;
		longint       dy;
		longint       nx;
		longint       ny;
		longint       cs;
		longint       sn;
		longint       one;
		logic         clip;
		xform_point_t r;
		dx   = longint'(px) - longint'(cx);
		dy   = longint'(py) - longint'(cy);
		nx   = longint'(px);
		ny   = longint'(py);
		one  = longint'(1) <<< TRIG_FRAC;
		clip = 1'b0;
		case (op)
			OP_ROTATE: begin
				cordic_sin_cos(ang, cs, sn);
				nx = trunc_toward_zero(cs * dx - sn * dy + longint'(cx) * one, TRIG_FRAC);
				ny = trunc_toward_zero(sn * dx + cs * dy + longint'(cy) * one, TRIG_FRAC);
			end
			OP_SCALE: begin
				nx = trunc_toward_zero(longint'(fct) * dx + (longint'(cx) <<< SCALE_FRAC),
					SCALE_FRAC);
				ny = trunc_toward_zero(longint'(fct) * dy + (longint'(cy) <<< SCALE_FRAC),
					SCALE_FRAC);
			end
			OP_MOVE: begin
				nx = longint'(px) + longint'(sx);
				ny = longint'(py) + longint'(sy);
			end
			default: begin
			end
		endcase
		nx     = clamp_coord(nx, clip);
		ny     = clamp_coord(ny, clip);
		r.x    = coord_t'(nx);
		r.y    = coord_t'(ny);
		r.clip = clip;
		return r;
	endfunction

	function automatic int check_field(input string name, input longint want, input longint got);
		if (want == got)
			return 0;
		$error("%s mismatch: expected %0d, actual %0d", name, want, got);
		return 1;
	endfunction

	always @(posedge clk) begin
		xform_point_t want;
		int           errs;
		int           seen;
		int           clips;
		errs  = 0;
		seen  = 0;
		clips = 0;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_points.size() == 0) begin
					$error("result transaction (%0d, %0d, %0b) with no prediction pending",
						new_x, new_y, clipped);
					errs++;
				end else begin
					want = pending_points.pop_front();
					errs += check_field("new_x", longint'(want.x), longint'(new_x));
					errs += check_field("new_y", longint'(want.y), longint'(new_y));
					errs += check_field("clipped", longint'(want.clip), longint'(clipped));
					seen  = 1;
					clips = want.clip ? 1 : 0;
				end
			end
			if (in_valid && in_ready)
				pending_points.push_back(transform_point(opcode, point_x, point_y, center_x,
					center_y, angle, scale_factor, shift_x, shift_y));
		end
		mismatch_count   <= mismatch_count + errs;
		results_checked  <= results_checked + seen;
		clipped_seen     <= clipped_seen + clips;
		points_in_flight <= pending_points.size();
	end

endmodule

// ----- dv/tb_point_rotate_scale_translate_core.sv -----
// Testbench top for the point transform core: stimulus, handshake pressure and the verdict.
module tb_point_rotate_scale_translate_core;

	import prst_pkg::*;

	// This limit is far beyond the slowest legal run.
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 650;
	// The last stretch of random transactions runs with no idling on either side.
	localparam int CALM_ITEMS   = 80;
	// The drain wait covers the full pipeline depth with margin.
	localparam int DRAIN_CYCLES = CORDIC_STAGES + 20;

	logic   clk = 1'b0;
	logic   arst_n;
	logic   in_valid;
	logic   in_ready;
	op_t    opcode;
	coord_t point_x;
	coord_t point_y;
	coord_t center_x;
	coord_t center_y;
	ang_t   angle;
	fact_t  scale_factor;
	coord_t shift_x;
	coord_t shift_y;
	logic   out_valid;
	logic   out_ready;
	coord_t new_x;
	coord_t new_y;
	logic   clipped;

	int mismatch_count;
	int points_in_flight;
	int results_checked;
	int clipped_seen;

	// Both sides stop idling once this is set, so the tail of the run is full rate.
	logic calm_tail = 1'b0;
	int   cycle_count = 0;
	int   op_tally [4] = '{0, 0, 0, 0};

	always #10 clk = ~clk;

	point_rotate_scale_translate_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.point_x      (point_x),
		.point_y      (point_y),
		.center_x     (center_x),
		.center_y     (center_y),
		.angle        (angle),
		.scale_factor (scale_factor),
		.shift_x      (shift_x),
		.shift_y      (shift_y),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.new_x        (new_x),
		.new_y        (new_y),
		.clipped      (clipped)
	);

	// The checker sits beside the core, watches both channels and keeps the
	// predictions; the top only reads back its counters for the verdict.
	point_xform_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.opcode           (opcode),
		.point_x          (point_x),
		.point_y          (point_y),
		.center_x         (center_x),
		.center_y         (center_y),
		.angle            (angle),
		.scale_factor     (scale_factor),
		.shift_x          (shift_x),
		.shift_y          (shift_y),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.new_x            (new_x),
		.new_y            (new_y),
		.clipped          (clipped),
		.mismatch_count   (mismatch_count),
		.points_in_flight (points_in_flight),
		.results_checked  (results_checked),
		.clipped_seen     (clipped_seen)
	);

	// A hung handshake or a prediction that never gets its result ends up here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycle_count, points_in_flight);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Receiver side: out_ready drops in bursts, separated by runs of readiness
	// that are sometimes long, so stalls land on every phase of the pipeline
	// and the skid register, and also leave clean stretches.
	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm_tail && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			out_ready <= 1'b1;
			if ($urandom_range(0, 7) == 0)
				repeat (120) @(posedge clk);
			else
				repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// Presents one transaction and returns at the edge where it is taken.
	// The caller is always at a rising edge, so in_valid is raised here without
	// being lowered in the same step; an idle burst, when chosen, lowers it
	// first and raises it again once the burst is over.
	task automatic send_point(input op_t op, input coord_t px, input coord_t py,
			input coord_t cx, input coord_t cy, input ang_t ang, input fact_t fct,
			input coord_t sx, input coord_t sy, input logic gaps_on);
		if (gaps_on && !calm_tail && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		point_x      <= px;
		point_y      <= py;
		center_x     <= cx;
		center_y     <= cy;
		angle        <= ang;
		scale_factor <= fct;
		shift_x      <= sx;
		shift_y      <= sy;
		// in_ready is read before this edge's updates land, so it is the value
		// that the core presented at the edge.
		do
			@(posedge clk);
		while (!in_ready);
		op_tally[op]++;
	endtask

	// Coordinates are half full-range and half near the origin, so rotations
	// and scalings give both saturated and in-range results.
	function automatic coord_t pick_coord();
		if ($urandom_range(0, 1) == 0)
			return coord_t'($urandom());
		return coord_t'(int'($urandom_range(0, 4000)) - 2000);
	endfunction

	task automatic send_random_point(input logic gaps_on);
		int    pick;
		op_t   op;
		ang_t  ang;
		fact_t fct;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			op = OP_ROTATE;
		else if (pick < 65)
			op = OP_SCALE;
		else if (pick < 90)
			op = OP_MOVE;
		else
			op = OP_PASS;
		// Mostly angles within [-pi, pi]; the rest use the whole 16-bit range.
		if ($urandom_range(0, 4) != 0)
			ang = ang_t'(int'($urandom_range(0, 51472)) - 25736);
		else
			ang = ang_t'($urandom());
		// Factors between -4 and 4 keep many scalings in range.
		if ($urandom_range(0, 9) < 6)
			fct = fact_t'(int'($urandom_range(0, 2048)) - 1024);
		else
			fct = fact_t'($urandom());
		send_point(op, pick_coord(), pick_coord(), pick_coord(), pick_coord(), ang, fct,
			coord_t'($urandom()), coord_t'($urandom()), gaps_on);
	endtask

	initial begin
		in_valid     <= 1'b0;
		opcode       <= OP_ROTATE;
		point_x      <= '0;
		point_y      <= '0;
		center_x     <= '0;
		center_y     <= '0;
		angle        <= '0;
		scale_factor <= '0;
		shift_x      <= '0;
		shift_y      <= '0;
		arst_n       <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. Rotations cover zero, the fold boundary at pi/2 from
		// both sides, plus and minus pi, angles beyond pi up to the 16-bit
		// limits, and a corner-to-corner rotation that saturates.
		send_point(OP_ROTATE, 100, -200, 0, 0, 0, 0, 0, 0, 1'b1);
		send_point(OP_ROTATE, 1000, 0, 0, 0, 12868, 0, 0, 0, 1'b1);
		send_point(OP_ROTATE, 1000, 0, 0, 0, 12867, 0, 0, 0, 1'b1);
		send_point(OP_ROTATE, 1000, 500, 0, 0, -12868, 0, 0, 0, 1'b1);
		send_point(OP_ROTATE, -5000, 7000, 1, -1, 25736, 0, 0, 0, 1'b1);
		send_point(OP_ROTATE, -5000, 7000, 1, -1, -25736, 0, 0, 0, 1'b1);
		send_point(OP_ROTATE, 3000, -4000, -20, 30, 32767, 0, 0, 0, 1'b1);
		send_point(OP_ROTATE, 3000, -4000, -20, 30, -32768, 0, 0, 0, 1'b1);
		send_point(OP_ROTATE, 32767, 32767, -32768, -32768, 6434, 0, 0, 0, 1'b1);
		send_point(OP_ROTATE, -32768, 32767, 32767, -32768, -19302, 0, 0, 0, 1'b1);
		send_point(OP_ROTATE, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1);
		// Scalings: unity, mirror through the center, the factor extremes with
		// opposite corners, truncation of a small negative product toward zero,
		// a zero factor, and a point sitting on its center.
		send_point(OP_SCALE, 1234, -4321, 10, 20, 0, 256, 0, 0, 1'b1);
		send_point(OP_SCALE, 1234, -4321, 10, 20, 0, -256, 0, 0, 1'b1);
		send_point(OP_SCALE, 32767, 32767, -32768, -32768, 0, 32767, 0, 0, 1'b1);
		send_point(OP_SCALE, -32768, 32767, 32767, -32768, 0, -32768, 0, 0, 1'b1);
		send_point(OP_SCALE, -3, 5, 0, 0, 0, 1, 0, 0, 1'b1);
		send_point(OP_SCALE, 777, -777, 5, -5, 0, 0, 0, 0, 1'b1);
		send_point(OP_SCALE, -1500, 2500, -1500, 2500, 0, 32767, 0, 0, 1'b1);
		// Translations: overflow in both directions, the extreme shifts, and a
		// plain move.
		send_point(OP_MOVE, 32767, -32768, 0, 0, 0, 0, 1, -1, 1'b1);
		send_point(OP_MOVE, -32768, 32767, 0, 0, 0, 0, -32768, 32767, 1'b1);
		send_point(OP_MOVE, 100, 200, 0, 0, 0, 0, -50, -300, 1'b1);
		// The unused opcode passes the point through, whatever the other fields hold.
		send_point(OP_PASS, -1, -1, -1, -1, -1, -1, -1, -1, 1'b1);
		send_point(OP_PASS, -32768, 32767, 32767, -32768, 25736, -32768, 32767, -32768, 1'b1);

		// Random part. Every third block of fifty transactions runs with no
		// gaps on the input side; the final stretch has no idling at all.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - CALM_ITEMS)
				calm_tail = 1'b1;
			send_random_point((i / 50) % 3 != 2);
		end
		in_valid <= 1'b0;

		while (points_in_flight != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d transactions: %0d rotate, %0d scale, %0d translate, %0d pass-through.",
			op_tally[OP_ROTATE] + op_tally[OP_SCALE] + op_tally[OP_MOVE] + op_tally[OP_PASS],
			op_tally[OP_ROTATE], op_tally[OP_SCALE], op_tally[OP_MOVE], op_tally[OP_PASS]);
		$display("Compared %0d results field by field, %0d of them saturated; %0d mismatches.",
			results_checked, clipped_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
